FILE: rtl/u8u16_pkg.sv
// ============================================================================
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ============================================================================
package u8u16_pkg;

    // Byte thresholds that set the sequence length of a lead byte
    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;

    // Code unit constants
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [5:0]  SURR_LOW_TOP   = 6'b110111;   // 0xDC00 >> 10
    localparam logic [21:0] SUPP_OFFSET    = 22'h010000;
    localparam logic [15:0] QMARK_UNIT     = 16'h003F;

    // Capacity register
    localparam int          CAP_W       = 13;
    localparam int          CNT_W       = 12;
    localparam logic [12:0] CAP_RESET   = 13'd256;
    localparam logic [12:0] CAP_MAX     = 13'd4096;
    localparam logic [11:0] LIMIT_RESET = 12'd255;

    // Register indexes (word address)
    localparam logic REG_OUT_CAPACITY = 1'b0;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_LOW,
        ST_TERM
    } state_t;

    // What the datapath loads into the output register
    typedef enum logic [2:0] {
        U_NONE,
        U_SEQ,
        U_HIGH,
        U_LOW,
        U_QMARK,
        U_TERM
    } unit_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load;        // take input beat into the byte buffer
        logic      clr_pend;    // drop pending bytes
        logic      clr_stream;  // end of string: back to stream reset
        logic [2:0] shift;      // bytes consumed from the buffer head
        unit_sel_t emit;        // unit to push into the output register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] cnt;        // bytes held in the buffer
        logic [2:0] need;       // sequence length of the head byte
        logic       last;       // buffer holds the final byte of the string
        logic       full;       // unit limit reached
        logic       pair_room;  // two more units fit
        logic       full_after; // one more unit reaches the limit
        logic       out_free;   // output register can take a unit
    } dp_stat_t;

endpackage

FILE: rtl/utf8_to_utf16_transcoder_core.sv
// ============================================================================
// utf8_to_utf16_transcoder_core
// UTF-8 byte stream in, UTF-16 code units out, zero terminator with the
// unit count at the end of each string.
// ============================================================================
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------
//  in        sink       in_valid / in_ready    in_byte, is_last
//  out       source     out_valid / out_ready  out_unit, is_end, unit_count
//  cfg       APB slave  psel/penable/pready    out_capacity at address 0
//
//  A byte is taken while idle, then each unit it gives passes in turn
//  through the single output register; a byte that arrives once the
//  output is full is dropped. On the final byte the units of a
//  cut-off reparse and then the terminator follow.
//  The input is ready only between bytes; out_ready low holds the controller.
//  Reset is asynchronous, active low; capacity returns to 256.
//
module utf8_to_utf16_transcoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    // output beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_unit,
    output logic        is_end,
    output logic [11:0] unit_count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    u8u16_pkg::dp_cmd_t  cmd;
    u8u16_pkg::dp_stat_t stat;
    logic                cfg_we;
    logic [12:0]         cap;

    // APB write decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[2] == u8u16_pkg::REG_OUT_CAPACITY);
    assign prdata = (paddr[2] == u8u16_pkg::REG_OUT_CAPACITY) ? {19'd0, cap} : 32'd0;

    u8u16_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .is_last  (is_last),
        .stat     (stat),
        .cmd      (cmd)
    );

    u8u16_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[12:0]),
        .cap        (cap),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_unit   (out_unit),
        .is_end     (is_end),
        .unit_count (unit_count)
    );

endmodule

FILE: rtl/u8u16_dp.sv
// ============================================================================
// u8u16_dp
// Datapath: capacity register, byte buffer, unit counters, code unit
// assembly and the output register.
// ============================================================================
module u8u16_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [12:0]          cfg_wdata,
    output logic [12:0]          cap,
    // input beat
    input  logic [7:0]           in_byte,
    input  logic                 is_last,
    // control
    input  u8u16_pkg::dp_cmd_t   cmd,
    output u8u16_pkg::dp_stat_t  stat,
    // output beat
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_unit,
    output logic                 is_end,
    output logic [11:0]          unit_count
);

    logic [12:0] cap_reg,   cap_next;
    logic [11:0] lim_reg,   lim_next;
    logic [7:0]  buf_reg  [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  cnt_reg,   cnt_next;
    logic        last_reg,  last_next;
    logic [11:0] wr_reg,    wr_next;
    logic        full_reg,  full_next;
    logic        ov_reg,    ov_next;
    logic [15:0] unit_reg,  unit_next;
    logic        end_reg,   end_next;
    logic [11:0] ucnt_reg,  ucnt_next;

    logic [7:0]  lead;
    logic [11:0] wr_inc;
    logic        out_free;
    logic [20:0] cp;
    logic [21:0] cpm;
    logic [15:0] seq_unit;
    logic [15:0] high_unit;
    logic [15:0] low_unit;
    logic [15:0] sel_unit;

    // Capacity register and derived unit limit (clamped capacity minus one)
    always_comb
    begin
        cap_next = cap_reg;
        lim_next = lim_reg;
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
            if (cfg_wdata == 13'd0)
                lim_next = 12'd0;
            else if (cfg_wdata > u8u16_pkg::CAP_MAX)
                lim_next = 12'hFFF;
            else
                lim_next = 12'(cfg_wdata - 13'd1);
        end
    end

    // Status toward the controller
    assign lead     = buf_reg[0];
    assign wr_inc   = wr_reg + 12'd1;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        stat.cnt = cnt_reg;
        if (lead < u8u16_pkg::LEAD_TWO)
            stat.need = 3'd1;
        else if (lead < u8u16_pkg::LEAD_THREE)
            stat.need = 3'd2;
        else if (lead < u8u16_pkg::LEAD_FOUR)
            stat.need = 3'd3;
        else
            stat.need = 3'd4;
        stat.last       = last_reg;
        stat.full       = full_reg || (wr_reg >= lim_reg);
        stat.pair_room  = ({1'b0, wr_reg} + 13'd2) <= {1'b0, lim_reg};
        stat.full_after = wr_inc >= lim_reg;
        stat.out_free   = out_free;
    end

    // Code unit assembly from the buffer head
    assign cp  = {lead[2:0], buf_reg[1][5:0], buf_reg[2][5:0], buf_reg[3][5:0]};
    assign cpm = {1'b0, cp} - u8u16_pkg::SUPP_OFFSET;
    // borrow bit extends the wrapped code point above bit 21
    assign high_unit = u8u16_pkg::SURR_HIGH_BASE + {{4{cpm[21]}}, cpm[21:10]};
    assign low_unit  = {u8u16_pkg::SURR_LOW_TOP, cpm[9:0]};

    always_comb
    begin
        unique case (stat.need)
            3'd1:    seq_unit = {8'h00, lead};
            3'd2:    seq_unit = {5'd0, lead[4:0], buf_reg[1][5:0]};
            3'd3:    seq_unit = {lead[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            default: seq_unit = high_unit;
        endcase
    end

    always_comb
    begin
        unique case (cmd.emit)
            u8u16_pkg::U_SEQ:   sel_unit = seq_unit;
            u8u16_pkg::U_HIGH:  sel_unit = high_unit;
            u8u16_pkg::U_LOW:   sel_unit = low_unit;
            u8u16_pkg::U_QMARK: sel_unit = u8u16_pkg::QMARK_UNIT;
            default:            sel_unit = 16'h0000;
        endcase
    end

    // Byte buffer, counters and output register next values
    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        wr_next   = wr_reg;
        full_next = full_reg;
        ov_next   = ov_reg && !out_ready;
        unit_next = unit_reg;
        end_next  = end_reg;
        ucnt_next = ucnt_reg;

        // append the accepted byte behind the pending ones
        if (cmd.load)
        begin
            buf_next[cnt_reg[1:0]] = in_byte;
            cnt_next               = cnt_reg + 3'd1;
            last_next              = is_last;
        end

        // consume bytes from the head
        if (cmd.shift != 3'd0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (i + int'(cmd.shift) < 4)
                    buf_next[i] = buf_reg[i + int'(cmd.shift)];
                else
                    buf_next[i] = 8'h00;
            end
            cnt_next = cnt_reg - cmd.shift;
        end

        // push a unit into the output register
        if (cmd.emit != u8u16_pkg::U_NONE)
        begin
            ov_next   = 1'b1;
            unit_next = sel_unit;
            end_next  = (cmd.emit == u8u16_pkg::U_TERM);
            ucnt_next = (cmd.emit == u8u16_pkg::U_TERM) ? wr_reg : 12'd0;
            if (cmd.emit != u8u16_pkg::U_TERM)
            begin
                wr_next = wr_inc;
                if (stat.full_after)
                    full_next = 1'b1;
            end
        end

        if (cmd.clr_pend)
            cnt_next = 3'd0;

        if (cmd.clr_stream)
        begin
            cnt_next  = 3'd0;
            wr_next   = 12'd0;
            full_next = 1'b0;
            last_next = 1'b0;
        end
    end

    // Control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= u8u16_pkg::CAP_RESET;
            lim_reg  <= u8u16_pkg::LIMIT_RESET;
            cnt_reg  <= 3'd0;
            last_reg <= 1'b0;
            wr_reg   <= 12'd0;
            full_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            cap_reg  <= cap_next;
            lim_reg  <= lim_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            wr_reg   <= wr_next;
            full_reg <= full_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        unit_reg <= unit_next;
        end_reg  <= end_next;
        ucnt_reg <= ucnt_next;
    end

    assign cap        = cap_reg;
    assign out_valid  = ov_reg;
    assign out_unit   = unit_reg;
    assign is_end     = end_reg;
    assign unit_count = ucnt_reg;

endmodule

FILE: rtl/u8u16_ctrl.sv
// ============================================================================
// u8u16_ctrl
// Controller: walks the byte buffer one sequence at a time and issues
// load, consume and emit commands to the datapath.
// ============================================================================
module u8u16_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 is_last,
    input  u8u16_pkg::dp_stat_t  stat,
    output u8u16_pkg::dp_cmd_t   cmd
);

    u8u16_pkg::state_t state_reg, state_next;

    u8u16_pkg::unit_sel_t act_sel;
    logic [2:0]           act_sh;
    logic                 complete;
    logic                 wait_more;
    logic [2:0]           rem;
    logic                 done;
    logic                 accept;

    assign accept = in_valid && (state_reg == u8u16_pkg::ST_IDLE);

    // Decide the action for the sequence at the buffer head
    always_comb
    begin
        complete  = stat.cnt >= stat.need;
        wait_more = 1'b0;
        act_sel   = u8u16_pkg::U_NONE;
        act_sh    = 3'd0;
        if (state_reg == u8u16_pkg::ST_LOW)
        begin
            act_sel = u8u16_pkg::U_LOW;
            act_sh  = 3'd4;
        end
        else if (complete)
        begin
            priority if (stat.need != 3'd4)
            begin
                act_sel = u8u16_pkg::U_SEQ;
                act_sh  = stat.need;
            end
            else if (stat.pair_room)
            begin
                act_sel = u8u16_pkg::U_HIGH;
                act_sh  = 3'd0;
            end
            else
            begin
                act_sel = u8u16_pkg::U_QMARK;
                act_sh  = 3'd1;
            end
        end
        else if (stat.last)
        begin
            // cut-off lead: '?' for the lead, reparse the rest
            act_sel = u8u16_pkg::U_QMARK;
            act_sh  = 3'd1;
        end
        else
        begin
            wait_more = 1'b1;
        end
        rem  = stat.cnt - act_sh;
        done = (rem == 3'd0) || stat.full_after;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            u8u16_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // a byte taken while full is dropped; only the end mark counts
                    if (stat.full)
                        state_next = is_last ? u8u16_pkg::ST_TERM : u8u16_pkg::ST_IDLE;
                    else
                        state_next = u8u16_pkg::ST_PARSE;
                end
            end
            u8u16_pkg::ST_PARSE, u8u16_pkg::ST_LOW:
            begin
                if (wait_more)
                    state_next = u8u16_pkg::ST_IDLE;
                else if (stat.out_free)
                begin
                    if (act_sel == u8u16_pkg::U_HIGH)
                        state_next = u8u16_pkg::ST_LOW;
                    else if (done)
                        state_next = stat.last ? u8u16_pkg::ST_TERM : u8u16_pkg::ST_IDLE;
                    else
                        state_next = u8u16_pkg::ST_PARSE;
                end
            end
            u8u16_pkg::ST_TERM:
            begin
                if (stat.out_free)
                    state_next = u8u16_pkg::ST_IDLE;
            end
            default: state_next = u8u16_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        cmd.emit       = u8u16_pkg::U_NONE;
        in_ready       = 1'b0;
        unique case (state_reg)
            u8u16_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load     = accept;
                cmd.clr_pend = accept && stat.full;
            end
            u8u16_pkg::ST_PARSE, u8u16_pkg::ST_LOW:
            begin
                if (!wait_more && stat.out_free)
                begin
                    cmd.emit  = act_sel;
                    cmd.shift = act_sh;
                    // limit reached: pending bytes are dropped
                    if (act_sel != u8u16_pkg::U_HIGH && stat.full_after)
                        cmd.clr_pend = 1'b1;
                end
            end
            u8u16_pkg::ST_TERM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = u8u16_pkg::U_TERM;
                    cmd.clr_stream = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= u8u16_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/u8u16_checker.sv
// ============================================================================
// u8u16_checker
// Port-level checks for the transcoder, bound to the top level.
// ============================================================================
module u8u16_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_unit,
    input logic        is_end,
    input logic [11:0] unit_count,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled output beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(is_end))
        else $error("output beat changed while stalled");

    // terminator carries a zero unit
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> out_unit == 16'd0)
        else $error("terminator unit not zero");

    // count shows only on the terminator
    a_count_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> unit_count == 12'd0)
        else $error("unit count on a non-terminator beat");

    // capacity register reads back within its width, port always ready
    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:13] == 19'd0 && pready)
        else $error("configuration read out of range");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_unit   (out_unit),
    .is_end     (is_end),
    .unit_count (unit_count),
    .prdata     (prdata),
    .pready     (pready)
);
